FILE: hdl/iqdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqdm_pkg
// Shared types, constants and the quarter-wave sine generator for the
// quadrature downconversion mixer.
// ----------------------------------------------------------------------------
package iqdm_pkg;

  // default sizes
  localparam int PHASE_BITS_DEFAULT      = 32;
  localparam int TABLE_ADDR_BITS_DEFAULT = 10;
  localparam int SAMPLE_BITS_DEFAULT     = 16;

  // configuration word and oscillator word formats
  localparam int CFG_BITS  = 32;
  localparam int WAVE_BITS = 16;   // signed Q1.15
  localparam int MAG_BITS  = 15;   // unsigned magnitude of a table entry
  localparam int WAVE_FRAC = 15;
  localparam int Q15_HALF  = 1 << (WAVE_FRAC - 1);

  // fixed-point constants for the table builder
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] AMPLITUDE   = 64'd32767;

  // oscillator outputs for one phase
  typedef struct packed {
    logic signed [WAVE_BITS-1:0] cos_val;
    logic signed [WAVE_BITS-1:0] neg_sin;
  } sincos_t;

  // one quarter-wave entry, Taylor series in Q30 through the x^15 term
  function automatic logic [MAG_BITS-1:0] quarter_sine(input int unsigned r,
                                                       input int unsigned addr_bits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    int                 n;
    x    = (HALF_PI_Q30 * 64'(r) + (64'd1 << (addr_bits - 3))) >> (addr_bits - 2);
    term = x;
    sum  = $signed(x);
    for (n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    v = ($unsigned(sum) * AMPLITUDE + (64'd1 << 29)) >> 30;
    if (v > AMPLITUDE) begin
      v = AMPLITUDE;
    end
    return v[MAG_BITS-1:0];
  endfunction

endpackage

FILE: hdl/iqdm_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqdm_sincos
// Phase to cosine / negated sine lookup from a quarter-wave constant table
// with quadrant folding.
// ----------------------------------------------------------------------------
module iqdm_sincos #(
  parameter int TABLE_ADDR_BITS = iqdm_pkg::TABLE_ADDR_BITS_DEFAULT
) (
  input  logic [TABLE_ADDR_BITS-1:0] addr,
  output iqdm_pkg::sincos_t          wave
);

  localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
  localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
  localparam int IDX_BITS     = QUARTER_BITS + 1;

  logic [iqdm_pkg::MAG_BITS-1:0] quarter_wave [QUARTER_LEN+1];

  // constant quarter-wave table, evaluated at elaboration
  for (genvar r = 0; r <= QUARTER_LEN; r++) begin : g_quarter
    assign quarter_wave[r] = iqdm_pkg::quarter_sine(r, TABLE_ADDR_BITS);
  end

  logic [1:0]              quad_sin;
  logic [1:0]              quad_cos;
  logic [QUARTER_BITS-1:0] offset;
  logic [IDX_BITS-1:0]     idx_fwd;
  logic [IDX_BITS-1:0]     idx_rev;
  logic [iqdm_pkg::WAVE_BITS-1:0] mag_sin;
  logic [iqdm_pkg::WAVE_BITS-1:0] mag_cos;

  // quadrant and offset; cosine sits one quadrant ahead
  assign quad_sin = addr[TABLE_ADDR_BITS-1 -: 2];
  assign quad_cos = quad_sin + 2'd1;
  assign offset   = addr[QUARTER_BITS-1:0];
  assign idx_fwd  = {1'b0, offset};
  assign idx_rev  = IDX_BITS'(QUARTER_LEN) - idx_fwd;

  // mirrored read in odd quadrants
  assign mag_sin = {1'b0, quad_sin[0] ? quarter_wave[idx_rev] : quarter_wave[idx_fwd]};
  assign mag_cos = {1'b0, quad_cos[0] ? quarter_wave[idx_rev] : quarter_wave[idx_fwd]};

  // sign from the upper half of the turn
  always_comb begin
    wave.neg_sin = quad_sin[1] ? $signed(mag_sin) : -$signed(mag_sin);
    wave.cos_val = quad_cos[1] ? -$signed(mag_cos) : $signed(mag_cos);
  end

endmodule

FILE: hdl/iq_downconversion_mixer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_downconversion_mixer_core
// Digital downconverter: real samples mixed with a numerically controlled
// oscillator into in-phase and quadrature results.
// ----------------------------------------------------------------------------
// Usage
//   cfg channel: phase_increment is the oscillator step per sample,
//     frequency / sample_rate * 2^PHASE_BITS. cfg_ready is always high;
//     write it only while no item is in flight.
//   in channel: one signed sample_in per item, valid / ready.
//   out channel: in_phase = round(sample * cos), quadrature =
//     round(sample * -sin), both Q1.15 scaled, one result per item.
//   The oscillator phase used for an item is the one before that item;
//   the accumulator then advances by phase_increment.
// Pipeline
//   An accepted item is held in the input register, then loaded into the
//   result register, where it can be taken. Throughput is one item per
//   cycle while the receiver does not stall: the table lookup sits in front
//   of the input register, the multiply and rounding in front of the
//   result register.
// Reset clears the phase accumulator, the increment and both pipeline
// stages. When the receiver stalls, the result holds, the input register
// keeps one more item, and in_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module iq_downconversion_mixer_core #(
  parameter int PHASE_BITS      = iqdm_pkg::PHASE_BITS_DEFAULT,
  parameter int TABLE_ADDR_BITS = iqdm_pkg::TABLE_ADDR_BITS_DEFAULT,
  parameter int SAMPLE_BITS     = iqdm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [iqdm_pkg::CFG_BITS-1:0] phase_increment,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] in_phase,
  output logic signed [SAMPLE_BITS-1:0] quadrature
);

  localparam int PROD_W = SAMPLE_BITS + iqdm_pkg::WAVE_BITS;
  localparam logic signed [PROD_W-1:0] ROUND_Q15 = PROD_W'(iqdm_pkg::Q15_HALF);

  logic [PHASE_BITS-1:0]      phase_step;
  logic [PHASE_BITS-1:0]      step_ext;
  logic [PHASE_BITS-1:0]      phase_accumulator;
  logic [TABLE_ADDR_BITS-1:0] table_addr;
  iqdm_pkg::sincos_t          wave;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  iqdm_pkg::sincos_t             s1_wave;

  logic in_accept;
  logic out_load;

  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rnd_i;
  logic signed [PROD_W-1:0] rnd_q;

  // increment fitted to the accumulator width
  if (PHASE_BITS <= iqdm_pkg::CFG_BITS) begin : g_step_trunc
    assign step_ext = phase_increment[PHASE_BITS-1:0];
  end else begin : g_step_zext
    assign step_ext = {{(PHASE_BITS - iqdm_pkg::CFG_BITS){1'b0}}, phase_increment};
  end

  assign cfg_ready = 1'b1;

  // handshake and stage moves
  assign out_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // increment register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
    end else if (cfg_valid && cfg_ready) begin
      phase_step <= step_ext;
    end
  end

  // phase accumulator, advances once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accumulator <= '0;
    end else if (in_accept) begin
      phase_accumulator <= phase_accumulator + phase_step;
    end
  end

  // oscillator lookup on the top accumulator bits
  assign table_addr = phase_accumulator[PHASE_BITS-1 -: TABLE_ADDR_BITS];

  iqdm_sincos #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_sincos (
    .addr(table_addr),
    .wave(wave)
  );

  // input stage: sample with its oscillator values
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample <= sample_in;
      s1_wave   <= wave;
    end
  end

  // mix and round half up back to Q1.15
  assign prod_i = PROD_W'(s1_sample) * PROD_W'(s1_wave.cos_val);
  assign prod_q = PROD_W'(s1_sample) * PROD_W'(s1_wave.neg_sin);
  assign rnd_i  = prod_i + ROUND_Q15;
  assign rnd_q  = prod_q + ROUND_Q15;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      in_phase   <= rnd_i[iqdm_pkg::WAVE_FRAC +: SAMPLE_BITS];
      quadrature <= rnd_q[iqdm_pkg::WAVE_FRAC +: SAMPLE_BITS];
    end
  end

endmodule

FILE: hdl/iqdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqdm_checker
// Port-level checks of the mixer pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module iqdm_checker #(
  parameter int SAMPLE_BITS = iqdm_pkg::SAMPLE_BITS_DEFAULT
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] in_phase,
  input logic signed [SAMPLE_BITS-1:0] quadrature
);

  // a stalled result holds its values
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(in_phase) && $stable(quadrature))
    else $error("result changed while stalled");

  // a new result comes from an accepted item that passed the input register
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted item");

  // an empty result register never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // configuration is never refused
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  // reset leaves no result pending
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind iq_downconversion_mixer_core iqdm_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_iqdm_checker (
  .clk(clk),
  .rst(rst),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .in_phase(in_phase),
  .quadrature(quadrature)
);
